// ===== hw/rtl/i2cblm_pkg.sv =====
package i2cblm_pkg;

  localparam logic [7:0] AckTimeoutReset = 8'd250;
  localparam logic [4:0] SendLastPhase   = 5'd24;
  localparam logic [4:0] ReadBitPhases   = 5'd16;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WAIT  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    SUB_SET_SDA = 2'd0,
    SUB_SCL_HI  = 2'd1,
    SUB_SCL_LO  = 2'd2
  } send_sub_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } out_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [4:0] phase;
    send_sub_e  sub;
    logic [7:0] shift;
    logic [7:0] poll;
    logic       scl;
    logic       sda;
    logic       sda_en;
    logic       ack;
    logic       fail;
    logic [7:0] rx;
  } seq_state_t;

endpackage

// ===== hw/rtl/i2c_bit_level_master.sv =====
// Channel  | Direction | Handshake             | Payload
// in       | input     | in_valid_i / in_stall_o   | in_data_i (i2cblm_pkg::in_t)
// out      | output    | out_valid_o / out_stall_i | out_data_o (i2cblm_pkg::out_t)
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (ack_timeout)
// One tick per clock while the result is not stalled: input register, one pass of phase logic, result register.
// A tick's result is registered in the result register after the input register and the phase logic;
// throughput is one per cycle while out_stall_i is low.
// Reset leaves lines released high, SCL high, no command active, timeout 250.
// A stalled result holds; the input register keeps taking ticks until it is full too.
module i2c_bit_level_master (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  i2cblm_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output i2cblm_pkg::out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_data_i
);

  logic             in_vld_q;
  i2cblm_pkg::in_t  in_q;
  logic             out_vld_q;
  i2cblm_pkg::out_t out_q;
  i2cblm_pkg::out_t res;
  logic [7:0]       timeout_q;
  logic             adv;
  logic             step;

  assign adv        = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      timeout_q <= i2cblm_pkg::AckTimeoutReset;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (adv) out_vld_q <= in_vld_q;
      if (cfg_valid_i && cfg_ready_o) timeout_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_q <= in_data_i;
    if (step) out_q <= res;
  end

  i2cblm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (step),
    .item_i        (in_q),
    .ack_timeout_i (timeout_q),
    .res_o         (res)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/i2cblm_seq.sv =====
module i2cblm_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  i2cblm_pkg::in_t  item_i,
  input  logic [7:0]       ack_timeout_i,
  output i2cblm_pkg::out_t res_o
);

  i2cblm_pkg::seq_state_t st_q, st_d;
  logic                   fin;
  logic [4:0]             nxt;
  logic [8:0]             poll_inc;

  always_comb begin
    st_d     = st_q;
    fin      = 1'b0;
    poll_inc = 9'd0;
    if (st_q.cmd == i2cblm_pkg::CMD_NONE &&
        item_i.command >= 3'(i2cblm_pkg::CMD_START) &&
        item_i.command <= 3'(i2cblm_pkg::CMD_WAIT)) begin
      st_d.cmd   = i2cblm_pkg::cmd_e'(item_i.command);
      st_d.phase = 5'd0;
      st_d.poll  = 8'd0;
      if (item_i.command == 3'(i2cblm_pkg::CMD_SEND)) st_d.shift = item_i.tx_byte;
      if (item_i.command == 3'(i2cblm_pkg::CMD_READ)) st_d.ack = item_i.send_ack;
      if (item_i.command == 3'(i2cblm_pkg::CMD_WAIT)) st_d.fail = 1'b0;
    end
    nxt = st_d.phase + 5'd1;
    unique case (st_d.cmd)
      i2cblm_pkg::CMD_START: begin
        if (st_d.phase == 5'd0) begin
          st_d.sda_en = 1'b1;
          st_d.sda    = 1'b1;
        end else if (st_d.phase == 5'd1) begin
          st_d.scl = 1'b1;
        end else if (st_d.phase == 5'd2) begin
          st_d.sda = 1'b0;
        end else begin
          st_d.scl = 1'b0;
          fin      = 1'b1;
        end
      end
      i2cblm_pkg::CMD_STOP: begin
        if (st_d.phase == 5'd0) begin
          st_d.sda_en = 1'b1;
          st_d.scl    = 1'b0;
        end else if (st_d.phase == 5'd1) begin
          st_d.sda = 1'b0;
        end else if (st_d.phase == 5'd2) begin
          st_d.scl = 1'b1;
        end else begin
          st_d.sda = 1'b1;
          fin      = 1'b1;
        end
      end
      i2cblm_pkg::CMD_SEND: begin
        if (st_d.phase == 5'd0) begin
          st_d.sda_en = 1'b1;
          st_d.scl    = 1'b0;
          st_d.sub    = i2cblm_pkg::SUB_SET_SDA;
        end else begin
          unique case (st_d.sub)
            i2cblm_pkg::SUB_SET_SDA: begin
              st_d.sda   = st_d.shift[7];
              st_d.shift = {st_d.shift[6:0], 1'b0};
              st_d.sub   = i2cblm_pkg::SUB_SCL_HI;
            end
            i2cblm_pkg::SUB_SCL_HI: begin
              st_d.scl = 1'b1;
              st_d.sub = i2cblm_pkg::SUB_SCL_LO;
            end
            default: begin
              st_d.scl = 1'b0;
              st_d.sub = i2cblm_pkg::SUB_SET_SDA;
              if (st_d.phase >= i2cblm_pkg::SendLastPhase) fin = 1'b1;
            end
          endcase
        end
      end
      i2cblm_pkg::CMD_READ: begin
        if (st_d.phase < i2cblm_pkg::ReadBitPhases) begin
          if (!st_d.phase[0]) begin
            if (st_d.phase == 5'd0) st_d.sda_en = 1'b0;
            st_d.scl = 1'b0;
          end else begin
            st_d.scl = 1'b1;
            st_d.rx  = {st_d.rx[6:0], item_i.sda_in};
          end
        end else if (st_d.phase == 5'd16) begin
          st_d.scl = 1'b0;
        end else if (st_d.phase == 5'd17) begin
          st_d.sda_en = 1'b1;
          st_d.sda    = ~st_d.ack;
        end else if (st_d.phase == 5'd18) begin
          st_d.scl = 1'b1;
        end else begin
          st_d.scl = 1'b0;
          fin      = 1'b1;
        end
      end
      i2cblm_pkg::CMD_WAIT: begin
        if (st_d.phase == 5'd0) begin
          st_d.sda_en = 1'b0;
          st_d.sda    = 1'b1;
        end else if (st_d.phase == 5'd1) begin
          st_d.scl = 1'b1;
        end else begin
          nxt = 5'd2;
          if (!item_i.sda_in) begin
            st_d.scl = 1'b0;
            fin      = 1'b1;
          end else begin
            poll_inc = {1'b0, st_d.poll} + 9'd1;
            if (poll_inc > {1'b0, ack_timeout_i}) begin
              st_d.fail   = 1'b1;
              st_d.cmd    = i2cblm_pkg::CMD_STOP;
              st_d.sda_en = 1'b1;
              st_d.scl    = 1'b0;
              nxt         = 5'd1;
            end else begin
              st_d.poll = poll_inc[7:0];
            end
          end
        end
      end
      default: ;
    endcase
    if (st_d.cmd != i2cblm_pkg::CMD_NONE) begin
      if (fin) begin
        st_d.cmd   = i2cblm_pkg::CMD_NONE;
        st_d.phase = 5'd0;
      end else begin
        st_d.phase = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{cmd: i2cblm_pkg::CMD_NONE, phase: 5'd0, sub: i2cblm_pkg::SUB_SET_SDA,
                shift: 8'd0, poll: 8'd0, scl: 1'b1, sda: 1'b1, sda_en: 1'b0,
                ack: 1'b0, fail: 1'b0, rx: 8'd0};
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign res_o.scl        = st_d.scl;
  assign res_o.sda_level  = st_d.sda;
  assign res_o.sda_enable = st_d.sda_en;
  assign res_o.busy_res   = (st_d.cmd != i2cblm_pkg::CMD_NONE);
  assign res_o.done_res   = fin;
  assign res_o.rx_byte    = st_d.rx;
  assign res_o.ack_failed = st_d.fail;

endmodule
